// ===== design/tlbw_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbw_pkg: shared constants and types for the thick line brush walker
// Field widths, coordinate format, command and register codes.
// ----------------------------------------------------------------------------
package tlbw_pkg;

	localparam int COORD_BITS = 12;
	localparam int FIELD_W    = 12;
	localparam int DIM_W      = 11;
	localparam int BRUSH_W    = 6;
	localparam int COLOR_W    = 16;
	localparam int CFG_IDX_W  = 1;

	// Error term and its doubled form used by the step compare.
	localparam int ERR_W  = COORD_BITS + 3;
	localparam int DBL_W  = COORD_BITS + 4;
	// Signed width that holds a brush corner and a display bound.
	localparam int RECT_W = (COORD_BITS + 2 > DIM_W + 1) ? COORD_BITS + 2 : DIM_W + 1;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] DISPLAY_RESET = 11'd240;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS:0]   delta_t;
	typedef logic signed [ERR_W-1:0]      err_t;
	typedef logic signed [RECT_W-1:0]     rect_t;

	// Takes the low COORD_BITS bits of a port field as a signed coordinate.
	function automatic coord_t coord_of(input logic [FIELD_W-1:0] raw);
		coord_of = coord_t'(COORD_BITS'(raw));
	endfunction

endpackage

// ===== design/thick_line_brush_walker.sv =====
// ----------------------------------------------------------------------------
// thick_line_brush_walker: Bresenham line stepper with a square brush
// Emits one clipped brush rectangle per line point for a fill engine.
// ----------------------------------------------------------------------------
// Usage
// Input channel (in_valid / in_stall) takes one command item: a start item
// loads both endpoints, the brush size and the colour and yields the brush at
// the start point; a step item advances one point along the line. A step with
// no line in progress is consumed and yields nothing.
// Output channel (out_valid / out_stall) delivers one rectangle per result,
// clipped to the display, with rect_empty set when nothing is left of it and
// last_point set on the end point.
// An item passes an input register and then the result register. One item
// is taken every cycle while the receiver does not stall; the whole step,
// including the clip, is worked out between the two registers. When the
// receiver stalls, the result register holds its item and the input register
// holds the next one, after which in_stall rises. Reset empties both
// registers, drops any line and sets both display sizes to 240. The user must
// write display sizes through wr_en / wr_index / wr_data only while no item
// is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module thick_line_brush_walker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [tlbw_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [tlbw_pkg::DIM_W-1:0]        wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              command,
	input  logic signed [tlbw_pkg::FIELD_W-1:0] start_x,
	input  logic signed [tlbw_pkg::FIELD_W-1:0] start_y,
	input  logic signed [tlbw_pkg::FIELD_W-1:0] end_x,
	input  logic signed [tlbw_pkg::FIELD_W-1:0] end_y,
	input  logic [tlbw_pkg::BRUSH_W-1:0]      brush_size,
	input  logic [tlbw_pkg::COLOR_W-1:0]      color_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tlbw_pkg::DIM_W-1:0]        rect_left,
	output logic [tlbw_pkg::DIM_W-1:0]        rect_top,
	output logic [tlbw_pkg::DIM_W-1:0]        rect_right,
	output logic [tlbw_pkg::DIM_W-1:0]        rect_bottom,
	output logic                              rect_empty,
	output logic                              last_point,
	output logic [tlbw_pkg::COLOR_W-1:0]      color_out
);
	import tlbw_pkg::*;

	// Configuration
	logic [DIM_W-1:0] disp_w_q, disp_h_q;

	// Input register
	logic               valid_s1;
	logic               cmd_s1;
	coord_t             sx_s1, sy_s1, ex_s1, ey_s1;
	logic [BRUSH_W-1:0] brush_s1;
	logic [COLOR_W-1:0] color_s1;

	// Line state
	coord_t             cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	delta_t             delta_x_q, delta_y_neg_q;
	logic               step_x_neg_q, step_y_neg_q;
	err_t               err_q;
	logic [BRUSH_W-1:0] brush_q;
	logic [COLOR_W-1:0] color_q;
	logic               active_q;

	// Next line state
	coord_t             nx_cur_x, nx_cur_y, nx_goal_x, nx_goal_y;
	delta_t             nx_delta_x, nx_delta_y_neg, dx, dy;
	logic               nx_step_x_neg, nx_step_y_neg;
	err_t               nx_err;
	logic [BRUSH_W-1:0] nx_brush;
	logic [COLOR_W-1:0] nx_color;
	logic               nx_last;
	logic signed [DBL_W-1:0] dbl;
	logic               move_x, move_y;

	// Brush rectangle
	rect_t              lx, ty, rx, by, wx, hy, lc, tc, rc, bc;
	logic               nx_empty;

	logic in_accept, has_result, out_free, adv;

	// Result register
	logic               out_valid_q;
	logic [DIM_W-1:0]   left_q, top_q, right_q, bottom_q;
	logic               empty_q, last_q;
	logic [COLOR_W-1:0] color_out_q;

	assign has_result = (cmd_s1 == CMD_START) || active_q;
	assign out_free   = !out_valid_q || !out_stall;
	assign adv        = valid_s1 && (!has_result || out_free);
	assign in_stall   = valid_s1 && !adv;
	assign in_accept  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_w_q <= DISPLAY_RESET;
			disp_h_q <= DISPLAY_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_DISPLAY_WIDTH:  disp_w_q <= wr_data;
				REG_DISPLAY_HEIGHT: disp_h_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1   <= command;
			sx_s1    <= coord_of(start_x);
			sy_s1    <= coord_of(start_y);
			ex_s1    <= coord_of(end_x);
			ey_s1    <= coord_of(end_y);
			brush_s1 <= brush_size;
			color_s1 <= color_in;
		end
	end

	always_comb begin
		nx_cur_x       = cur_x_q;
		nx_cur_y       = cur_y_q;
		nx_goal_x      = goal_x_q;
		nx_goal_y      = goal_y_q;
		nx_delta_x     = delta_x_q;
		nx_delta_y_neg = delta_y_neg_q;
		nx_step_x_neg  = step_x_neg_q;
		nx_step_y_neg  = step_y_neg_q;
		nx_err         = err_q;
		nx_brush       = brush_q;
		nx_color       = color_q;
		dx             = {ex_s1[COORD_BITS-1], ex_s1} - {sx_s1[COORD_BITS-1], sx_s1};
		dy             = {ey_s1[COORD_BITS-1], ey_s1} - {sy_s1[COORD_BITS-1], sy_s1};
		dbl            = {err_q, 1'b0};
		move_x         = dbl >= $signed({{(DBL_W-COORD_BITS-1){delta_y_neg_q[COORD_BITS]}},
			delta_y_neg_q});
		move_y         = dbl <= $signed({{(DBL_W-COORD_BITS-1){delta_x_q[COORD_BITS]}},
			delta_x_q});
		if (cmd_s1 == CMD_START) begin
			nx_cur_x       = sx_s1;
			nx_cur_y       = sy_s1;
			nx_goal_x      = ex_s1;
			nx_goal_y      = ey_s1;
			nx_brush       = brush_s1;
			nx_color       = color_s1;
			nx_delta_x     = dx[COORD_BITS] ? -dx : dx;
			nx_delta_y_neg = dy[COORD_BITS] ? dy : -dy;
			nx_step_x_neg  = !(sx_s1 < ex_s1);
			nx_step_y_neg  = !(sy_s1 < ey_s1);
			nx_err         = {{2{nx_delta_x[COORD_BITS]}}, nx_delta_x}
				+ {{2{nx_delta_y_neg[COORD_BITS]}}, nx_delta_y_neg};
		end else begin
			if (move_x) begin
				nx_cur_x = step_x_neg_q ? cur_x_q - coord_t'(1) : cur_x_q + coord_t'(1);
			end
			if (move_y) begin
				nx_cur_y = step_y_neg_q ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1);
			end
			nx_err = err_q
				+ (move_x ? {{2{delta_y_neg_q[COORD_BITS]}}, delta_y_neg_q} : err_t'(0))
				+ (move_y ? {{2{delta_x_q[COORD_BITS]}}, delta_x_q} : err_t'(0));
		end
		nx_last = (nx_cur_x == nx_goal_x) && (nx_cur_y == nx_goal_y);
	end

	// The brush's top-left corner sits half a side up and left of the point.
	always_comb begin
		lx = {{(RECT_W-COORD_BITS){nx_cur_x[COORD_BITS-1]}}, nx_cur_x}
			- {{(RECT_W-BRUSH_W+1){1'b0}}, nx_brush[BRUSH_W-1:1]};
		ty = {{(RECT_W-COORD_BITS){nx_cur_y[COORD_BITS-1]}}, nx_cur_y}
			- {{(RECT_W-BRUSH_W+1){1'b0}}, nx_brush[BRUSH_W-1:1]};
		rx = lx + {{(RECT_W-BRUSH_W){1'b0}}, nx_brush};
		by = ty + {{(RECT_W-BRUSH_W){1'b0}}, nx_brush};
		wx = {{(RECT_W-DIM_W){1'b0}}, disp_w_q};
		hy = {{(RECT_W-DIM_W){1'b0}}, disp_h_q};
		lc = lx[RECT_W-1] ? rect_t'(0) : lx;
		tc = ty[RECT_W-1] ? rect_t'(0) : ty;
		rc = (rx > wx) ? wx : rx;
		bc = (by > hy) ? hy : by;
		nx_empty = (lc >= rc) || (tc >= bc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			goal_x_q      <= '0;
			goal_y_q      <= '0;
			delta_x_q     <= '0;
			delta_y_neg_q <= '0;
			step_x_neg_q  <= 1'b0;
			step_y_neg_q  <= 1'b0;
			err_q         <= '0;
			brush_q       <= '0;
			color_q       <= '0;
			active_q      <= 1'b0;
		end else if (adv && has_result) begin
			cur_x_q       <= nx_cur_x;
			cur_y_q       <= nx_cur_y;
			goal_x_q      <= nx_goal_x;
			goal_y_q      <= nx_goal_y;
			delta_x_q     <= nx_delta_x;
			delta_y_neg_q <= nx_delta_y_neg;
			step_x_neg_q  <= nx_step_x_neg;
			step_y_neg_q  <= nx_step_y_neg;
			err_q         <= nx_err;
			brush_q       <= nx_brush;
			color_q       <= nx_color;
			active_q      <= !nx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_result) begin
			left_q      <= nx_empty ? '0 : lc[DIM_W-1:0];
			top_q       <= nx_empty ? '0 : tc[DIM_W-1:0];
			right_q     <= nx_empty ? '0 : rc[DIM_W-1:0];
			bottom_q    <= nx_empty ? '0 : bc[DIM_W-1:0];
			empty_q     <= nx_empty;
			last_q      <= nx_last;
			color_out_q <= nx_color;
		end
	end

	assign out_valid   = out_valid_q;
	assign rect_left   = left_q;
	assign rect_top    = top_q;
	assign rect_right  = right_q;
	assign rect_bottom = bottom_q;
	assign rect_empty  = empty_q;
	assign last_point  = last_q;
	assign color_out   = color_out_q;

endmodule

// ===== design/tlbw_checker.sv =====
// ----------------------------------------------------------------------------
// tlbw_checker: port checks for the thick line brush walker
// Watches the result channel for stall behaviour and rectangle consistency.
// ----------------------------------------------------------------------------
module tlbw_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [tlbw_pkg::DIM_W-1:0]        rect_left,
	input logic [tlbw_pkg::DIM_W-1:0]        rect_top,
	input logic [tlbw_pkg::DIM_W-1:0]        rect_right,
	input logic [tlbw_pkg::DIM_W-1:0]        rect_bottom,
	input logic                              rect_empty,
	input logic                              last_point,
	input logic [tlbw_pkg::COLOR_W-1:0]      color_out
);

	// A stalled result stays on the port, with its bounds, last_point and colour unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rect_left) && $stable(rect_right)
			&& $stable(rect_top) && $stable(rect_bottom) && $stable(last_point)
			&& $stable(color_out))
		else $error("result item changed while stalled");

	// An empty brush carries all-zero bounds.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rect_empty |-> rect_left == '0 && rect_top == '0
			&& rect_right == '0 && rect_bottom == '0)
		else $error("empty rectangle with non-zero bounds");

	// A non-empty brush covers at least one pixel in each direction.
	a_rect_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rect_empty |-> rect_left < rect_right && rect_top < rect_bottom)
		else $error("non-empty rectangle with inverted bounds");

	// Nothing can be in the result register on the first cycle after reset.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid straight after reset");

endmodule

bind thick_line_brush_walker tlbw_checker u_tlbw_checker (.*);

// ===== verif/thick_line_brush_walker_checker.sv =====
// ----------------------------------------------------------------------------
// thick_line_brush_walker_checker: brush rectangle scoreboard
// Follows the register port and both channels, walks every line alongside the
// block and compares each rectangle that leaves it with the predicted one.
// ----------------------------------------------------------------------------
module thick_line_brush_walker_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [tlbw_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [tlbw_pkg::DIM_W-1:0]          wr_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                command,
	input  logic signed [tlbw_pkg::FIELD_W-1:0] start_x,
	input  logic signed [tlbw_pkg::FIELD_W-1:0] start_y,
	input  logic signed [tlbw_pkg::FIELD_W-1:0] end_x,
	input  logic signed [tlbw_pkg::FIELD_W-1:0] end_y,
	input  logic [tlbw_pkg::BRUSH_W-1:0]        brush_size,
	input  logic [tlbw_pkg::COLOR_W-1:0]        color_in,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [tlbw_pkg::DIM_W-1:0]          rect_left,
	input  logic [tlbw_pkg::DIM_W-1:0]          rect_top,
	input  logic [tlbw_pkg::DIM_W-1:0]          rect_right,
	input  logic [tlbw_pkg::DIM_W-1:0]          rect_bottom,
	input  logic                                rect_empty,
	input  logic                                last_point,
	input  logic [tlbw_pkg::COLOR_W-1:0]        color_out,
	output int                                  errors,
	output int                                  pending
);
	import tlbw_pkg::*;

	typedef struct packed {
		logic [DIM_W-1:0]   left_col;
		logic [DIM_W-1:0]   top_row;
		logic [DIM_W-1:0]   right_col;
		logic [DIM_W-1:0]   bottom_row;
		logic               empty;
		logic               last;
		logic [COLOR_W-1:0] color;
	} brush_rect_t;

	brush_rect_t expected_brushes[$];
	brush_rect_t want;
	int          brush_count;

	logic [DIM_W-1:0]   disp_w, disp_h;
	coord_t             cur_x, cur_y, goal_x, goal_y;
	delta_t             delta_x, delta_y_neg;
	err_t               err_term;
	logic               step_x_neg, step_y_neg;
	logic [BRUSH_W-1:0] brush_reg;
	logic [COLOR_W-1:0] color_reg;
	logic               line_active;

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 60)
			$display("ERROR: %s", msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("brush %0d: %s is %0d, expected %0d",
				brush_count, name, got, exp_val));
	endtask

	// Advances the line by one command item and queues the brush it yields.
	task automatic walk_line(input logic cmd, input logic [FIELD_W-1:0] sx,
			input logic [FIELD_W-1:0] sy, input logic [FIELD_W-1:0] ex,
			input logic [FIELD_W-1:0] ey, input logic [BRUSH_W-1:0] br,
			input logic [COLOR_W-1:0] col);
		int          dx, dy, dbl, half, l, t, r, b;
		logic        at_goal;
		logic        emitted;
		brush_rect_t rect;
		emitted = 1'b0;
		at_goal = 1'b0;
		if (cmd == CMD_START) begin
			cur_x = coord_t'(sx[COORD_BITS-1:0]);
			cur_y = coord_t'(sy[COORD_BITS-1:0]);
			goal_x = coord_t'(ex[COORD_BITS-1:0]);
			goal_y = coord_t'(ey[COORD_BITS-1:0]);
			brush_reg = br;
			color_reg = col;
			dx = int'(goal_x) - int'(cur_x);
			dy = int'(goal_y) - int'(cur_y);
			delta_x = delta_t'(dx < 0 ? -dx : dx);
			delta_y_neg = delta_t'(dy < 0 ? dy : -dy);
			step_x_neg = !(cur_x < goal_x);
			step_y_neg = !(cur_y < goal_y);
			err_term = err_t'(int'(delta_x) + int'(delta_y_neg));
			at_goal = (cur_x == goal_x) && (cur_y == goal_y);
			line_active = !at_goal;
			emitted = 1'b1;
		end else if (line_active) begin
			// Both moves are decided on the error term as it stood before the step.
			dbl = 2 * int'(err_term);
			if (dbl >= int'(delta_y_neg)) begin
				err_term = err_t'(int'(err_term) + int'(delta_y_neg));
				cur_x = coord_t'(int'(cur_x) + (step_x_neg ? -1 : 1));
			end
			if (dbl <= int'(delta_x)) begin
				err_term = err_t'(int'(err_term) + int'(delta_x));
				cur_y = coord_t'(int'(cur_y) + (step_y_neg ? -1 : 1));
			end
			at_goal = (cur_x == goal_x) && (cur_y == goal_y);
			line_active = !at_goal;
			emitted = 1'b1;
		end
		if (emitted) begin
			half = int'(brush_reg) / 2;
			l = int'(cur_x) - half;
			t = int'(cur_y) - half;
			r = l + int'(brush_reg);
			b = t + int'(brush_reg);
			if (l < 0) l = 0;
			if (t < 0) t = 0;
			if (r > int'(disp_w)) r = int'(disp_w);
			if (b > int'(disp_h)) b = int'(disp_h);
			rect = '0;
			if (l >= r || t >= b) begin
				rect.empty = 1'b1;
			end else begin
				rect.left_col = l[DIM_W-1:0];
				rect.top_row = t[DIM_W-1:0];
				rect.right_col = r[DIM_W-1:0];
				rect.bottom_row = b[DIM_W-1:0];
			end
			rect.last = at_goal;
			rect.color = color_reg;
			expected_brushes.push_back(rect);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_brushes.delete();
			errors = 0;
			pending = 0;
			brush_count = 0;
			disp_w = DISPLAY_RESET;
			disp_h = DISPLAY_RESET;
			cur_x = '0;
			cur_y = '0;
			goal_x = '0;
			goal_y = '0;
			delta_x = '0;
			delta_y_neg = '0;
			err_term = '0;
			step_x_neg = 1'b0;
			step_y_neg = 1'b0;
			brush_reg = '0;
			color_reg = '0;
			line_active = 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_DISPLAY_WIDTH: disp_w = wr_data;
					REG_DISPLAY_HEIGHT: disp_h = wr_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_brushes.size() == 0) begin
					report_mismatch($sformatf("brush %0d arrived with none expected",
						brush_count));
				end else begin
					want = expected_brushes.pop_front();
					check_field("rect_left", 32'(rect_left), 32'(want.left_col));
					check_field("rect_top", 32'(rect_top), 32'(want.top_row));
					check_field("rect_right", 32'(rect_right), 32'(want.right_col));
					check_field("rect_bottom", 32'(rect_bottom), 32'(want.bottom_row));
					check_field("rect_empty", 32'(rect_empty), 32'(want.empty));
					check_field("last_point", 32'(last_point), 32'(want.last));
					check_field("color_out", 32'(color_out), 32'(want.color));
				end
				brush_count++;
			end
			if (in_valid && !in_stall)
				walk_line(command, start_x, start_y, end_x, end_y, brush_size, color_in);
			pending = expected_brushes.size();
		end
	end

endmodule

// ===== verif/thick_line_brush_walker_tb.sv =====
// ----------------------------------------------------------------------------
// thick_line_brush_walker_tb: testbench top for the thick line brush walker
// Drives short directed lines and then random lines over several display
// sizes, with bursty input and a stalling receiver; the checker scores it.
// ----------------------------------------------------------------------------
module thick_line_brush_walker_tb;
	import tlbw_pkg::*;

	localparam int ITEMS_PER_PHASE = 265;
	localparam int PHASES          = 7;
	localparam int IDLE_LIMIT      = 2000;
	localparam int DRAIN_CYCLES    = 8;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     wr_en      = 1'b0;
	logic [CFG_IDX_W-1:0]     wr_index   = '0;
	logic [DIM_W-1:0]         wr_data    = '0;
	logic                     in_valid   = 1'b0;
	logic                     command    = CMD_START;
	logic signed [FIELD_W-1:0] start_x   = '0;
	logic signed [FIELD_W-1:0] start_y   = '0;
	logic signed [FIELD_W-1:0] end_x     = '0;
	logic signed [FIELD_W-1:0] end_y     = '0;
	logic [BRUSH_W-1:0]       brush_size = '0;
	logic [COLOR_W-1:0]       color_in   = '0;
	logic                     out_stall  = 1'b0;
	logic                     in_stall;
	logic                     out_valid;
	logic [DIM_W-1:0]         rect_left, rect_top, rect_right, rect_bottom;
	logic                     rect_empty, last_point;
	logic [COLOR_W-1:0]       color_out;
	int                       errors, pending;

	int burst_left  = 0;
	int items_sent  = 0;
	int stall_run   = 0;
	int idle_cycles = 0;
	int disp_w      = int'(DISPLAY_RESET);
	int disp_h      = int'(DISPLAY_RESET);
	bit calm        = 1'b0;

	thick_line_brush_walker uut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .start_x(start_x), .start_y(start_y),
		.end_x(end_x), .end_y(end_y), .brush_size(brush_size), .color_in(color_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.rect_left(rect_left), .rect_top(rect_top), .rect_right(rect_right),
		.rect_bottom(rect_bottom), .rect_empty(rect_empty), .last_point(last_point),
		.color_out(color_out)
	);

	thick_line_brush_walker_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .start_x(start_x), .start_y(start_y),
		.end_x(end_x), .end_y(end_y), .brush_size(brush_size), .color_in(color_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.rect_left(rect_left), .rect_top(rect_top), .rect_right(rect_right),
		.rect_bottom(rect_bottom), .rect_empty(rect_empty), .last_point(last_point),
		.color_out(color_out),
		.errors(errors), .pending(pending)
	);

	always #4 clk = ~clk;

	// The receiver alternates short stalls with open runs, some of them long.
	always @(negedge clk) begin
		if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			stall_run <= ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80)
				: $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b1;
			stall_run <= $urandom_range(0, 9);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int clamp_coord(input int v);
		return (v < -2048) ? -2048 : ((v > 2047) ? 2047 : v);
	endfunction

	// A coordinate around the visible area, reaching a little past each edge.
	function automatic int near_display(input int extent);
		return clamp_coord(int'($urandom_range(0, extent + 80)) - 40);
	endfunction

	task automatic send_item(input logic cmd, input int sx, input int sy, input int ex,
			input int ey, input int brush, input int color);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = calm ? 0 : (($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
				: $urandom_range(0, 3));
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		command = cmd;
		start_x = sx[FIELD_W-1:0];
		start_y = sy[FIELD_W-1:0];
		end_x = ex[FIELD_W-1:0];
		end_y = ey[FIELD_W-1:0];
		brush_size = brush[BRUSH_W-1:0];
		color_in = color[COLOR_W-1:0];
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Starts a line and gives it a number of step items with junk in the
	// unused fields; steps past the end point are ignored by the block.
	task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
			input int brush, input int color, input int nsteps);
		int adx, ady, need;
		adx = (ex > sx) ? ex - sx : sx - ex;
		ady = (ey > sy) ? ey - sy : sy - ey;
		need = (adx > ady) ? adx : ady;
		send_item(CMD_START, sx, sy, ex, ey, brush, color);
		repeat (nsteps)
			send_item(CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		items_sent += 1 + ((nsteps < need) ? nsteps : need);
	endtask

	task automatic random_line();
		int sx, sy, ex, ey, span, need, adx, ady, pick, nsteps;
		if ($urandom_range(0, 11) == 0)
			calm = !calm;
		if ($urandom_range(0, 9) == 0) begin
			// Anywhere in the coordinate range; usually dropped long before its end.
			sx = int'($urandom_range(0, 4095)) - 2048;
			sy = int'($urandom_range(0, 4095)) - 2048;
			ex = int'($urandom_range(0, 4095)) - 2048;
			ey = int'($urandom_range(0, 4095)) - 2048;
			nsteps = $urandom_range(0, 6);
		end else begin
			span = ($urandom_range(0, 5) == 0) ? 60 : 12;
			sx = near_display(disp_w);
			sy = near_display(disp_h);
			ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
			ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
			adx = (ex > sx) ? ex - sx : sx - ex;
			ady = (ey > sy) ? ey - sy : sy - ey;
			need = (adx > ady) ? adx : ady;
			pick = $urandom_range(0, 9);
			if (pick < 2)
				nsteps = $urandom_range(0, need);
			else if (pick < 4)
				nsteps = need + $urandom_range(1, 3);
			else
				nsteps = need;
		end
		draw_line(sx, sy, ex, ey, $urandom_range(0, 63), $urandom_range(0, 65535), nsteps);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = value[DIM_W-1:0];
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	// Lets every expected brush arrive, then covers items still in flight
	// that yield nothing.
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int w, h;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				wait_drained();
				case (p)
					1: begin w = 1; h = 1; end
					2: begin w = 1024; h = 1024; end
					3: begin w = 0; h = 7; end
					4: begin w = 2047; h = 2047; end
					5: begin w = $urandom_range(1, 1024); h = $urandom_range(1, 1024); end
					default: begin w = 13; h = 600; end
				endcase
				write_reg(REG_DISPLAY_WIDTH, w);
				write_reg(REG_DISPLAY_HEIGHT, h);
				disp_w = w;
				disp_h = h;
			end else begin
				// A step with no line in progress.
				send_item(CMD_STEP, 0, 0, 0, 0, 0, 0);
				// Extreme corners, widest brush, then a restart while the line runs.
				draw_line(-2048, 2047, 2047, -2048, 63, 16'hFFFF, 2);
				draw_line(2047, -2048, -2048, 2047, 62, 0, 1);
				// Start on the end point: one last brush and the line stays idle.
				draw_line(10, 10, 10, 10, 1, 16'h1234, 1);
				// Brush hanging over the right and bottom edges.
				draw_line(239, 239, 241, 238, 63, 16'hA5A5, 2);
				// Zero brush size never covers a pixel.
				draw_line(0, 0, -3, 1, 0, 16'h5A5A, 3);
				// Entirely off the left edge.
				draw_line(-40, 5, -38, 5, 8, 16'h00FF, 2);
				// Vertical line followed by a step past its end.
				draw_line(3, 3, 3, 5, 7, 16'hFF00, 3);
			end
			while (items_sent < (p + 1) * ITEMS_PER_PHASE)
				random_line();
		end

		wait_drained();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
design/tlbw_pkg.sv
design/thick_line_brush_walker.sv
design/tlbw_checker.sv
verif/thick_line_brush_walker_checker.sv
verif/thick_line_brush_walker_tb.sv
